>>> sv/ansc_pkg.sv
`default_nettype none

package ansc_pkg;

    localparam logic [7:0] ZeroByte  = 8'h00;
    localparam logic [7:0] StartByte = 8'h01;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [2:0][7:0] hold;
        logic [1:0]      count;
        logic            inside_nal;
        logic            prefix_emitted;
        logic            any_nal_seen;
    } scan_state_t;

    typedef struct packed {
        logic [6:0][7:0] data;
        logic [2:0]      count;
        logic            unit_end;
        logic            no_nal_found;
        logic            bare;
    } burst_t;

    localparam scan_state_t ScanReset = '0;

endpackage

`default_nettype wire

>>> sv/ansc_step.sv
`default_nettype none

module ansc_step (
    input  var ansc_pkg::scan_state_t state,
    input  wire [7:0]                 in_byte,
    input  wire                       end_of_unit,
    output ansc_pkg::scan_state_t     state_next,
    output ansc_pkg::burst_t          burst
);

    logic            start_code;
    logic [2:0][7:0] hold_mid;
    logic [1:0]      count_mid;
    logic            emit_old;
    logic            inside_mid;
    logic            flush;
    logic [2:0]      payload_count;
    logic            need_prefix;
    logic            any_new;
    logic [2:0]      k;
    logic [6:0][7:0] data;

    always_comb begin
        start_code = (in_byte == ansc_pkg::StartByte) && (state.count >= 2'd2) &&
                     (state.hold[state.count - 2'd1] == ansc_pkg::ZeroByte) &&
                     (state.hold[state.count - 2'd2] == ansc_pkg::ZeroByte);
        hold_mid  = state.hold;
        count_mid = state.count;
        emit_old  = 1'b0;
        if (start_code) begin
            emit_old  = state.inside_nal && (state.count == 2'd3) &&
                        (state.hold[0] != ansc_pkg::ZeroByte);
            count_mid = 2'd0;
        end else if (state.count == 2'd3) begin
            emit_old    = state.inside_nal;
            hold_mid[0] = state.hold[1];
            hold_mid[1] = state.hold[2];
            hold_mid[2] = in_byte;
            count_mid   = 2'd3;
        end else begin
            hold_mid[state.count] = in_byte;
            count_mid             = state.count + 2'd1;
        end
        inside_mid    = start_code || state.inside_nal;
        flush         = end_of_unit && inside_mid;
        payload_count = {2'b00, emit_old} + (flush ? {1'b0, count_mid} : 3'd0);
        need_prefix   = !state.prefix_emitted && (payload_count != 3'd0);
        any_new       = state.any_nal_seen || (payload_count != 3'd0);
    end

    always_comb begin
        data = '0;
        k    = 3'd0;
        if (need_prefix) begin
            data[0] = ansc_pkg::ZeroByte;
            data[1] = ansc_pkg::ZeroByte;
            data[2] = ansc_pkg::StartByte;
            k       = 3'd3;
        end
        if (emit_old) begin
            data[k] = state.hold[0];
            k       = k + 3'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (flush && (2'(i) < count_mid)) begin
                data[k] = hold_mid[i];
                k       = k + 3'd1;
            end
        end
    end

    always_comb begin
        burst.data         = data;
        burst.bare         = end_of_unit && (k == 3'd0);
        burst.count        = burst.bare ? 3'd1 : k;
        burst.unit_end     = end_of_unit;
        burst.no_nal_found = !any_new;

        if (end_of_unit) begin
            state_next = ansc_pkg::ScanReset;
        end else begin
            state_next.hold           = hold_mid;
            state_next.count          = count_mid;
            state_next.inside_nal     = inside_mid;
            state_next.prefix_emitted = start_code ? 1'b0 :
                                        (state.prefix_emitted || (payload_count != 3'd0));
            state_next.any_nal_seen   = any_new;
        end
    end

endmodule

`default_nettype wire

>>> sv/ansc_burst.sv
`default_nettype none

module ansc_burst (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  load,
    input  var ansc_pkg::burst_t burst_in,
    output logic                 free,
    output logic                 m_valid,
    input  wire                  m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_byte_valid,
    output logic                 m_unit_end,
    output logic                 m_no_nal_found
);

    ansc_pkg::burst_t burst_reg;
    ansc_pkg::burst_t burst_next;
    logic             pop;

    assign m_valid        = (burst_reg.count != 3'd0);
    assign pop            = m_valid && m_ready;
    assign free           = (burst_reg.count == 3'd0) || ((burst_reg.count == 3'd1) && pop);
    assign m_out_byte     = burst_reg.bare ? ansc_pkg::ZeroByte : burst_reg.data[0];
    assign m_byte_valid   = !burst_reg.bare;
    assign m_unit_end     = burst_reg.unit_end && (burst_reg.count == 3'd1);
    assign m_no_nal_found = burst_reg.unit_end && (burst_reg.count == 3'd1) &&
                            burst_reg.no_nal_found;

    always_comb begin
        burst_next = burst_reg;
        if (load) begin
            burst_next = burst_in;
        end else if (pop) begin
            burst_next.data  = burst_reg.data >> 8;
            burst_next.count = burst_reg.count - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_reg <= '0;
        end else begin
            burst_reg <= burst_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/annexb_start_code_normalizer_unit.sv
// Each accepted byte is held in the input register, then its results are loaded into the
// result register. Throughput: one byte per cycle while each byte causes at most one
// result and the output is not stalled; a byte that causes more (prefix plus payload,
// at most seven) holds the port while the single result register drains them one at a time.
// Reset (aresetn low at a clock edge) empties both registers and starts a new unit.
`default_nettype none

module annexb_start_code_normalizer_unit (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [7:0]  s_in_byte,
    input  wire        s_end_of_unit,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_unit_end,
    output logic       m_no_nal_found
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_eou_reg;
    ansc_pkg::scan_state_t state_reg;
    ansc_pkg::scan_state_t state_next;
    ansc_pkg::scan_state_t step_state;
    ansc_pkg::burst_t      step_burst;
    logic                  burst_free;
    logic                  load;
    logic                  in_xfer;

    assign load          = in_valid_reg && burst_free;
    assign s_ready       = !in_valid_reg || load;
    assign in_xfer       = s_valid && s_ready;
    assign in_valid_next = in_xfer || (in_valid_reg && !load);
    assign state_next    = load ? step_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ansc_pkg::ScanReset;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_byte_reg <= s_in_byte;
            in_eou_reg  <= s_end_of_unit;
        end
    end

    ansc_step u_step (
        .state       (state_reg),
        .in_byte     (in_byte_reg),
        .end_of_unit (in_eou_reg),
        .state_next  (step_state),
        .burst       (step_burst)
    );

    ansc_burst u_burst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .burst_in       (step_burst),
        .free           (burst_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_unit_end     (m_unit_end),
        .m_no_nal_found (m_no_nal_found)
    );

endmodule

`default_nettype wire

>>> sv/ansc_checker.sv
`default_nettype none

module ansc_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire [7:0] s_in_byte,
    input wire       s_end_of_unit,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_out_byte,
    input wire       m_byte_valid,
    input wire       m_unit_end,
    input wire       m_no_nal_found
);

    // A bare end marker carries no byte and always closes the unit.
    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_unit_end && (m_out_byte == 8'h00))
        else $error("bare result without unit end");

    // The no-NAL flag only appears on the closing result.
    a_flag_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_nal_found |-> m_unit_end)
        else $error("no_nal_found outside unit end");

    // A result that carries a byte means a NAL unit was emitted.
    a_byte_means_nal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> !m_no_nal_found)
        else $error("byte emitted with no_nal_found set");

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_unit_end))
        else $error("result changed while stalled");

    // A stalled input transfer keeps its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_in_byte) && $stable(s_end_of_unit))
        else $error("input changed while stalled");

endmodule

bind annexb_start_code_normalizer_unit ansc_checker u_ansc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_in_byte      (s_in_byte),
    .s_end_of_unit  (s_end_of_unit),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_byte_valid   (m_byte_valid),
    .m_unit_end     (m_unit_end),
    .m_no_nal_found (m_no_nal_found)
);

`default_nettype wire

>>> sim/annexb_start_code_normalizer_unit_tb.sv
`timescale 1ns / 1ps

module annexb_start_code_normalizer_unit_tb;

    typedef struct packed {
        ansc_pkg::byte_t data;
        logic            valid;
        logic            last;
        logic            empty_unit;
    } nal_beat_t;

    typedef struct packed {
        ansc_pkg::byte_t b;
        logic            eou;
        logic            typed;
        nal_beat_t       want;
    } stim_row_t;

    localparam nal_beat_t NoBeat  = '0;
    localparam nal_beat_t BareEnd = '{ansc_pkg::ZeroByte, 1'b0, 1'b1, 1'b1};

    localparam stim_row_t DirRows [0:24] = '{
        '{8'h00, 1'b1, 1'b1, BareEnd},
        '{8'h55, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h01, 1'b1, 1'b1, BareEnd},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h01, 1'b0, 1'b0, NoBeat},
        '{8'hcd, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h01, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h01, 1'b0, 1'b0, NoBeat},
        '{8'hef, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h00, 1'b0, 1'b0, NoBeat},
        '{8'h01, 1'b0, 1'b0, NoBeat},
        '{8'hff, 1'b0, 1'b0, NoBeat},
        '{8'h80, 1'b0, 1'b0, NoBeat},
        '{8'h7f, 1'b0, 1'b0, NoBeat},
        '{8'h3c, 1'b1, 1'b0, NoBeat}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_unit;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_unit_end;
    logic       m_no_nal_found;

    annexb_start_code_normalizer_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_unit  (s_end_of_unit),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_unit_end     (m_unit_end),
        .m_no_nal_found (m_no_nal_found)
    );

    ansc_pkg::byte_t held [3] = '{ansc_pkg::ZeroByte, ansc_pkg::ZeroByte, ansc_pkg::ZeroByte};
    logic [1:0] held_n = '0;
    logic       in_nal = 1'b0;
    logic       prefix_sent = 1'b0;
    logic       nal_seen = 1'b0;

    nal_beat_t  produced [$];
    nal_beat_t  pending_beats [$];
    stim_row_t  feed [$];

    int  fault_count = 0;
    int  beats_checked = 0;
    int  bytes_sent = 0;
    int  units_sent = 0;
    int  hold_at;
    int  drain_at;
    int  steady_at;
    bit  hold_off_req = 1'b0;
    bit  steady = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic emit_beat(input ansc_pkg::byte_t d, input logic v);
        produced.push_back('{d, v, 1'b0, 1'b0});
    endtask

    task automatic emit_payload(input ansc_pkg::byte_t d);
        if (!prefix_sent) begin
            emit_beat(ansc_pkg::ZeroByte, 1'b1);
            emit_beat(ansc_pkg::ZeroByte, 1'b1);
            emit_beat(ansc_pkg::StartByte, 1'b1);
            prefix_sent = 1'b1;
            nal_seen = 1'b1;
        end
        emit_beat(d, 1'b1);
    endtask

    // Works out the results that one accepted byte causes and advances the scan state.
    task automatic scan_byte(input ansc_pkg::byte_t b, input logic eou);
        int        n;
        nal_beat_t tail;
        n = held_n;
        produced.delete();
        if (b == ansc_pkg::StartByte && n >= 2 && held[n-1] == ansc_pkg::ZeroByte &&
            held[n-2] == ansc_pkg::ZeroByte) begin
            if (in_nal && n == 3 && held[0] != ansc_pkg::ZeroByte) begin
                emit_payload(held[0]);
            end
            in_nal = 1'b1;
            prefix_sent = 1'b0;
            n = 0;
        end else begin
            if (n == 3) begin
                if (in_nal) begin
                    emit_payload(held[0]);
                end
                held[0] = held[1];
                held[1] = held[2];
                n = 2;
            end
            held[n] = b;
            n++;
        end
        held_n = n[1:0];
        if (eou) begin
            if (in_nal) begin
                for (int i = 0; i < n; i++) begin
                    emit_payload(held[i]);
                end
            end
            if (produced.size() == 0) begin
                emit_beat(ansc_pkg::ZeroByte, 1'b0);
            end
            tail = produced.pop_back();
            tail.last = 1'b1;
            tail.empty_unit = !nal_seen;
            produced.push_back(tail);
            held = '{ansc_pkg::ZeroByte, ansc_pkg::ZeroByte, ansc_pkg::ZeroByte};
            held_n = '0;
            in_nal = 1'b0;
            prefix_sent = 1'b0;
            nal_seen = 1'b0;
        end
    endtask

    function automatic ansc_pkg::byte_t pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return ansc_pkg::ZeroByte;
        end else if (r == 3) begin
            return ansc_pkg::StartByte;
        end else if (r == 4) begin
            return 8'h03;
        end
        return ansc_pkg::byte_t'($urandom_range(0, 255));
    endfunction

    task automatic add_byte(input ansc_pkg::byte_t b);
        feed.push_back('{b, 1'b0, 1'b0, NoBeat});
    endtask

    // Mostly well-formed access units with random payload, with some noise and
    // broken start codes mixed in.
    task automatic plan_unit();
        int        len;
        int        nal_total;
        stim_row_t tail;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            repeat (len) add_byte(pick_byte());
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 4);
                repeat (len) add_byte(pick_byte());
            end
            nal_total = $urandom_range(1, 4);
            repeat (nal_total) begin
                if ($urandom_range(0, 1) == 1) begin
                    add_byte(ansc_pkg::ZeroByte);
                end
                add_byte(ansc_pkg::ZeroByte);
                add_byte(ansc_pkg::ZeroByte);
                add_byte(ansc_pkg::StartByte);
                len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                repeat (len) add_byte(pick_byte());
                if ($urandom_range(0, 7) == 0) begin
                    add_byte(ansc_pkg::ZeroByte);
                    add_byte(ansc_pkg::ZeroByte);
                end
            end
        end
        tail = feed.pop_back();
        tail.eou = 1'b1;
        feed.push_back(tail);
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            nal_beat_t want;
            beats_checked++;
            if (pending_beats.size() == 0) begin
                fault_count++;
                if (fault_count <= 20) begin
                    $display("%0t: unexpected result, expected none, ", $time,
                             "actual data %02h valid %0b end %0b empty %0b",
                             m_out_byte, m_byte_valid, m_unit_end, m_no_nal_found);
                end
            end else begin
                want = pending_beats.pop_front();
                if (m_out_byte !== want.data || m_byte_valid !== want.valid ||
                    m_unit_end !== want.last || m_no_nal_found !== want.empty_unit) begin
                    fault_count++;
                    if (fault_count <= 20) begin
                        $display("%0t: mismatch, ", $time,
                                 "expected data %02h valid %0b end %0b empty %0b, ",
                                 want.data, want.valid, want.last, want.empty_unit,
                                 "actual data %02h valid %0b end %0b empty %0b",
                                 m_out_byte, m_byte_valid, m_unit_end, m_no_nal_found);
                    end
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (64) @(negedge aclk);
                hold_off_req = 1'b0;
            end else if (steady || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end
        end
    end

    initial begin
        stim_row_t row;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = '0;
        s_end_of_unit = 1'b0;
        foreach (DirRows[i]) begin
            feed.push_back(DirRows[i]);
        end
        while (feed.size() < $size(DirRows) + 450) begin
            plan_unit();
        end
        hold_at = $size(DirRows) + 120;
        drain_at = $size(DirRows) + 240;
        steady_at = feed.size() - 60;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int idx = 0; idx < feed.size(); idx++) begin
            row = feed[idx];
            if (idx == hold_at) begin
                hold_off_req = 1'b1;
            end
            if (idx == drain_at) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending_beats.size() != 0) @(negedge aclk);
            end
            if (idx >= steady_at) begin
                steady = 1'b1;
            end
            if (!steady && !(idx >= hold_at && idx < hold_at + 40) &&
                $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_in_byte <= row.b;
            s_end_of_unit <= row.eou;
            @(posedge aclk);
            while (s_ready !== 1'b1) @(posedge aclk);
            scan_byte(row.b, row.eou);
            if (row.typed) begin
                pending_beats.push_back(row.want);
            end else begin
                foreach (produced[k]) begin
                    pending_beats.push_back(produced[k]);
                end
            end
            bytes_sent++;
            if (row.eou) begin
                units_sent++;
            end
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes in %0d access units and checked %0d results.",
                 bytes_sent, units_sent, beats_checked);
        $display("The run included empty NAL units, long zero runs, a long output stall and a full drain.");
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
